// ----- sv/label_class_histogram_macros.svh -----
// Assertion macros for the label class histogram.
// Included by the top level; no other dependencies.
`ifndef LABEL_CLASS_HISTOGRAM_MACROS_SVH
`define LABEL_CLASS_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
`define LCH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LCH_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- sv/lch_pkg.sv -----
// Shared types and constants of the label class histogram.
// No dependencies.
package lch_pkg;
	localparam int MAX_LABELS = 16;
	localparam int MAX_CLASSES = 48;
	localparam int LIW = $clog2(MAX_LABELS);
	localparam int CIW = $clog2(MAX_CLASSES);

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_VOXEL = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] KIND_CLASS = 2'd0;
	localparam logic [1:0] KIND_FREQ = 2'd1;
	localparam logic [1:0] KIND_GREY = 2'd2;

	localparam logic [1:0] REG_HAS_SEG = 2'd0;
	localparam logic [1:0] REG_NUM_LABELS = 2'd1;
	localparam logic [1:0] REG_GREY_LABEL = 2'd2;
	localparam logic [1:0] REG_NUM_CLASSES = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] entry_index;
		logic signed [15:0] label_value;
		logic [1:0] activation;
	} lch_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] slot;
		logic [16:0] value;
		logic error;
		logic last;
	} lch_out_t;

	// Classified work handed from front to back.
	typedef struct packed {
		logic finish;       // 1: report run, 0: voxel
		logic err;
		logic count;        // class histogram increment
		logic grey;         // grey counter increment
		logic [1:0] act;
		logic [6:0] cls;
	} lch_op_t;
endpackage

// ----- sv/lch_if.sv -----
// Valid/ready channel interface carrying one payload of type T.
// No dependencies; the payload type is a parameter.
interface lch_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/lch_front.sv -----
// Front part: takes input transfers, loads the label table, classifies voxels.
// Depends on lch_pkg.
module lch_front import lch_pkg::*; (
	input logic clk,
	input logic arst_n,
	lch_if.sink in,
	input logic has_seg,
	input logic [4:0] nl,
	input logic [15:0] grey_label,
	input logic [5:0] nc,
	output logic op_valid,
	output lch_op_t op,
	input logic op_full
);
	logic [15:0] table_q [MAX_LABELS];
	logic found;
	logic [LIW-1:0] hit;
	logic [6:0] cls;
	logic take;

	assign in.ready = !op_full;
	assign take = in.valid && in.ready;

	always_ff @(posedge clk) begin
		if (take && in.data.cmd == CMD_LOAD)
			table_q[in.data.entry_index] <= in.data.label_value;
	end

	// First matching entry below num_labels.
	always_comb begin
		found = 1'b0;
		hit = '0;
		for (int j = MAX_LABELS - 1; j >= 0; j--) begin
			if (5'(j) < nl && table_q[j] == in.data.label_value) begin
				found = 1'b1;
				hit = LIW'(j);
			end
		end
	end

	always_comb begin
		if (has_seg)
			cls = 7'(in.data.activation) * 7'(nl) + 7'(hit);
		else
			cls = 7'(in.data.activation);
		op = '0;
		op.finish = (in.data.cmd == CMD_FINISH);
		op.act = in.data.activation;
		if (has_seg && !found) begin
			op.err = 1'b1;
			op.cls = '0;
		end else begin
			op.cls = cls;
			op.err = (cls >= 7'(nc));
			op.count = !op.err;
			op.grey = !op.err && has_seg && in.data.label_value == grey_label
				&& in.data.activation != 2'd3;
		end
	end

	assign op_valid = take && (in.data.cmd == CMD_VOXEL || in.data.cmd == CMD_FINISH);
endmodule

// ----- sv/lch_queue.sv -----
// Two-entry queue between the front and back parts.
// Depends on lch_pkg.
module lch_queue import lch_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lch_op_t wdata,
	output logic full,
	input logic pop,
	output logic nonempty,
	output lch_op_t rdata
);
	lch_op_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- sv/lch_div.sv -----
// Restoring divider: floor(num*2^16/den) capped at 2^16, one bit a cycle.
// Depends on lch_pkg.
module lch_div import lch_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] num,
	input logic [33:0] den,
	output logic done,
	output logic [16:0] quo
);
	logic [34:0] rem_q;
	logic [33:0] den_q;
	logic [47:0] sh_q;
	logic [17:0] q_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [34:0] trial;

	assign trial = {rem_q[33:0], sh_q[47]};
	assign done = busy_q && cnt_q == 6'd0;
	// Quotient fits 48 bits; above 2^16 it saturates, flagged by high bits.
	assign quo = (q_q[17] || q_q[16:0] > 17'h10000) ? 17'h10000 : q_q[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd48;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			sh_q <= {num, 16'd0};
			q_q <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			sh_q <= {sh_q[46:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q <= (q_q[17] ? q_q : {q_q[16:0], 1'b1}) | {q_q[17] | q_q[16], 17'd0};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[17] | q_q[16], q_q[15:0], 1'b0};
			end
		end
	end
endmodule

// ----- sv/lch_back.sv -----
// Back part: class histogram memory, grey counters, report sequencer.
// Depends on lch_pkg and lch_div.
module lch_back import lch_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic op_nonempty,
	input lch_op_t op,
	output logic op_pop,
	input logic [5:0] nc,
	lch_if.source out,
	output logic busy
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_RD = 6'b000010, S_DIV = 6'b000100,
		S_WAIT = 6'b001000, S_OUT = 6'b010000, S_CLR = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] cnt_mem [MAX_CLASSES];
	logic [MAX_CLASSES-1:0] vld_q;
	logic [31:0] rd_q;
	logic [31:0] grey_q [3];
	logic [31:0] total_q;
	logic [6:0] idx_q;
	logic gphase_q;
	logic [5:0] nc_q;
	logic out_v_q;
	lch_out_t out_q;
	logic upd_v_q;
	logic [CIW-1:0] upd_cls_q;
	logic [CIW-1:0] rd_addr;
	logic div_start, div_done;
	logic [31:0] div_num;
	logic [33:0] div_den, gsum;
	logic [16:0] div_quo;
	logic [1:0] gi;
	logic voxel_go;

	assign gsum = 34'(grey_q[0]) + 34'(grey_q[1]) + 34'(grey_q[2]);
	assign gi = idx_q[1:0];
	assign out.valid = out_v_q;
	assign out.data = out_q;
	assign busy = state_q != S_IDLE || out_v_q || upd_v_q;
	// A voxel waits while the previous histogram update is still being written.
	assign voxel_go = state_q == S_IDLE && op_nonempty && !op.finish && !upd_v_q
		&& (!out_v_q || out.ready);
	assign op_pop = voxel_go || (state_q == S_CLR);
	assign rd_addr = voxel_go ? op.cls[CIW-1:0] : idx_q[CIW-1:0];

	lch_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));

	always_comb begin
		if (!gphase_q) begin
			div_num = (vld_q[idx_q[CIW-1:0]] && rd_q != 0) ? rd_q : 32'd1;
			div_den = 34'(total_q);
		end else begin
			div_num = grey_q[gi];
			div_den = gsum;
		end
	end
	assign div_start = state_q == S_DIV;

	// Histogram read-modify-write: the count is read into rd_q when the voxel
	// is taken and the incremented value is written back on the next cycle.
	always_ff @(posedge clk) begin
		rd_q <= cnt_mem[rd_addr];
		if (upd_v_q)
			cnt_mem[upd_cls_q] <= vld_q[upd_cls_q]
				? ((rd_q == '1) ? '1 : rd_q + 32'd1)
				: 32'd1;
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			out_q.kind <= gphase_q ? KIND_GREY : KIND_FREQ;
			out_q.slot <= idx_q[5:0];
			out_q.value <= (gphase_q && gsum == 0) ? 17'd0 : div_quo;
			out_q.error <= 1'b0;
			out_q.last <= gphase_q && gi == 2'd2;
		end else if (voxel_go) begin
			out_q.kind <= KIND_CLASS;
			out_q.slot <= '0;
			out_q.value <= 17'(op.cls);
			out_q.error <= op.err;
			out_q.last <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			grey_q <= '{default: '0};
			total_q <= '0;
			idx_q <= '0;
			gphase_q <= 1'b0;
			nc_q <= '0;
			out_v_q <= 1'b0;
			upd_v_q <= 1'b0;
			upd_cls_q <= '0;
		end else begin
			if (out_v_q && out.ready) out_v_q <= 1'b0;
			if (div_done) out_v_q <= 1'b1;
			else if (voxel_go) out_v_q <= 1'b1;
			upd_v_q <= voxel_go && op.count;
			if (voxel_go) upd_cls_q <= op.cls[CIW-1:0];
			if (upd_v_q) vld_q[upd_cls_q] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (voxel_go) begin
						if (total_q != '1) total_q <= total_q + 1;
						if (op.grey && grey_q[op.act] != '1)
							grey_q[op.act] <= grey_q[op.act] + 1;
					end else if (op_nonempty && op.finish && !out_v_q && !upd_v_q) begin
						nc_q <= (nc > 6'(MAX_CLASSES)) ? 6'(MAX_CLASSES) : nc;
						idx_q <= '0;
						gphase_q <= (nc == 6'd0);
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_DIV;
				S_DIV: state_q <= S_WAIT;
				S_WAIT: if (div_done) state_q <= S_OUT;
				S_OUT: begin
					if (!out_v_q) begin
						if (!gphase_q && idx_q + 7'd1 < 7'(nc_q)) begin
							idx_q <= idx_q + 7'd1;
							state_q <= S_RD;
						end else if (!gphase_q) begin
							gphase_q <= 1'b1;
							idx_q <= '0;
							state_q <= S_RD;
						end else if (gi != 2'd2) begin
							idx_q <= idx_q + 7'd1;
							state_q <= S_RD;
						end else state_q <= S_CLR;
					end
				end
				S_CLR: begin
					vld_q <= '0;
					grey_q <= '{default: '0};
					total_q <= '0;
					gphase_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/label_class_histogram.sv -----
// Top level of the label class histogram: configuration, front, queue, back.
// Depends on lch_pkg, lch_if, lch_front, lch_queue, lch_back and the macros header.
//
//  channel | direction | payload
//  in      | sink      | cmd, entry_index, label_value, activation
//  out     | source    | kind, slot, value, error, last
//
// A load transfer is taken whenever the queue has room. A counted voxel occupies
// the back part for a registered histogram read followed by the write-back;
// the next voxel waits for it and for the result channel to drain. Each report
// item passes the read, divider start, wait and output states, paced by the
// 48-step bit-serial divider. Reset clears counters and resets configuration;
// the label table is unknown until loaded. Either side may stall freely.
`include "label_class_histogram_macros.svh"
module label_class_histogram import lch_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	lch_if.sink in,
	lch_if.source out
);
	logic has_seg_q;
	logic [4:0] nl_q;
	logic [15:0] grey_q;
	logic [5:0] nc_q;
	logic [4:0] nl_sat;
	logic [5:0] nc_sat;
	logic op_valid, q_full, q_nonempty, op_pop, busy;
	lch_op_t op_w, op_r;

	// Configuration registers; num_labels and num_classes are saturated to the
	// table and histogram sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_seg_q <= 1'b0;
			nl_q <= 5'd1;
			grey_q <= '0;
			nc_q <= 6'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HAS_SEG: has_seg_q <= cfg_data[0];
				REG_NUM_LABELS: nl_q <= cfg_data[4:0];
				REG_GREY_LABEL: grey_q <= cfg_data;
				REG_NUM_CLASSES: nc_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end
	assign nl_sat = (nl_q > 5'(MAX_LABELS)) ? 5'(MAX_LABELS) : nl_q;
	assign nc_sat = (nc_q > 6'(MAX_CLASSES)) ? 6'(MAX_CLASSES) : nc_q;

	lch_front u_front (.clk, .arst_n, .in, .has_seg(has_seg_q), .nl(nl_sat),
		.grey_label(grey_q), .nc(nc_sat), .op_valid, .op(op_w), .op_full(q_full));

	lch_queue u_queue (.clk, .arst_n, .push(op_valid), .wdata(op_w), .full(q_full),
		.pop(op_pop), .nonempty(q_nonempty), .rdata(op_r));

	lch_back u_back (.clk, .arst_n, .op_nonempty(q_nonempty), .op(op_r), .op_pop,
		.nc(nc_sat), .out, .busy);

	`LCH_ASSERT(a_no_push_full, clk, arst_n, !(op_valid && q_full && !op_pop), "push into full queue")
	`LCH_ASSERT(a_no_pop_empty, clk, arst_n, !(op_pop && !q_nonempty), "pop from empty queue")
	`LCH_ASSERT_NEXT(a_out_hold, clk, arst_n, out.valid && !out.ready, out.valid, "result dropped")
	`LCH_ASSERT(a_cfg_idle, clk, arst_n, !(cfg_we && (busy || q_nonempty)), "configuration written while busy")
endmodule
